>>> hw/rtl/pidc_pkg.sv
// PID controller step: shared types, register indexes and constants.
// No dependencies; used by every other RTL file of the block.
`default_nettype none

package pidc_pkg;

  localparam int unsigned MeasW   = 16;
  localparam int unsigned GainW   = 16;
  localparam int unsigned ProdW   = 33;   // 16 x 17 signed product
  localparam int unsigned AccW    = 32;
  localparam int unsigned OffsetW = 12;
  localparam int unsigned DriveW  = 17;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic signed [33:0] ACC_SAT_MAX = 34'sh0_7FFF_FFFF;
  localparam logic signed [33:0] ACC_SAT_MIN = 34'sh3_8000_0000;

  localparam logic [31:0]        LIMITS_RESET = 32'h7FFF_8000;
  localparam logic [OffsetW-1:0] OFFSET_RESET = 12'd150;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SETPOINT     = 3'd0,
    REG_GAIN_P       = 3'd1,
    REG_GAIN_I       = 3'd2,
    REG_GAIN_D       = 3'd3,
    REG_OUT_LIMITS   = 3'd4,
    REG_INT_LIMITS   = 3'd5,
    REG_INT_CLAMP_EN = 3'd6,
    REG_DRIVE_OFFSET = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [MeasW-1:0] setpoint;
    logic signed [GainW-1:0] gain_p;
    logic signed [GainW-1:0] gain_i;
    logic signed [GainW-1:0] gain_d;
    logic signed [15:0]      out_max;
    logic signed [15:0]      out_min;
    logic signed [15:0]      int_max;
    logic signed [15:0]      int_min;
    logic                    int_clamp_en;
    logic [OffsetW-1:0]      drive_offset;
  } cfg_t;

  typedef struct packed {
    logic signed [ProdW-1:0] p;   // gain_p * error
    logic signed [ProdW-1:0] i;   // gain_i * error
    logic signed [ProdW-1:0] d;   // gain_d * (previous - measurement)
  } prod_t;

endpackage

`default_nettype wire

>>> hw/rtl/pidc_if.sv
// PID controller step: valid/ready channel interfaces for samples and drive beats.
// Depends on pidc_pkg for field widths.
`default_nettype none

interface pidc_in_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [pidc_pkg::MeasW-1:0]        measurement;

  modport source (output valid, output measurement, input ready);
  modport sink   (input valid, input measurement, output ready);
endinterface

interface pidc_out_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [pidc_pkg::DriveW-1:0]       drive;
  logic                                     saturated;

  modport source (output valid, output drive, output saturated, input ready);
  modport sink   (input valid, input drive, input saturated, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/pid_controller_step.sv
// PID controller step (derivative on measurement): top level.
// Depends on pidc_pkg, pidc_if, pidc_cfg_regs, pidc_prod_stage, pidc_sum_stage.
//
//   port    dir  beat payload             handshake
//   in_ch   in   measurement (s16)        valid/ready
//   out_ch  out  drive (s17), saturated   valid/ready
//   cfg_*   in   index 3b, data 32b       write enable, no back-pressure
//
// One beat per cycle sustained while out_ch.ready is high; an input beat passes the
// product register, then the result register, before result valid rises.
// in_ch.ready drops only while the product stage holds a beat that cannot move
// into a full, stalled result register.
// Synchronous active-low reset clears valids, integral, last sample; presets cfg.
`default_nettype none

module pid_controller_step #(
  parameter int unsigned GAIN_FRACTION_BITS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  pidc_in_if.sink                            in_ch,
  pidc_out_if.source                         out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [pidc_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [pidc_pkg::CfgDataW-1:0] cfg_wdata
);
  import pidc_pkg::*;

  cfg_t  cfg;
  prod_t prod;
  logic  s1_v_r;
  logic  s1_v_nxt;
  logic  out_v_r;
  logic  out_v_nxt;
  logic  out_free;
  logic  accept;
  logic  advance;

  assign out_free    = !out_v_r || out_ch.ready;
  assign advance     = s1_v_r && out_free;
  assign in_ch.ready = !s1_v_r || out_free;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_v_nxt  = accept ? 1'b1 : (advance ? 1'b0 : s1_v_r);
    out_v_nxt = advance ? 1'b1 : (out_ch.ready ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  pidc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pidc_prod_stage u_prod (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (accept),
    .measurement (in_ch.measurement),
    .cfg         (cfg),
    .prod        (prod)
  );

  pidc_sum_stage #(
    .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
  ) u_sum (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .prod      (prod),
    .cfg       (cfg),
    .drive     (out_ch.drive),
    .saturated (out_ch.saturated)
  );

  assign out_ch.valid = out_v_r;

`ifndef ASSERT_OFF
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !s1_v_r && !out_v_r)
    else $error("valids not cleared by reset");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_v_r)
    else $error("accepted beat lost from product stage");

  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_v_r)
    else $error("result register not filled on advance");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !out_free |=> s1_v_r && $stable(prod))
    else $error("stalled product stage changed");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/pidc_cfg_regs.sv
// PID controller step: configuration register file, write-only.
// Depends on pidc_pkg.
`default_nettype none

module pidc_cfg_regs (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [pidc_pkg::CfgIdxW-1:0]    cfg_index,
  input  wire logic [pidc_pkg::CfgDataW-1:0]   cfg_wdata,
  output pidc_pkg::cfg_t                       cfg
);
  import pidc_pkg::*;

  localparam cfg_t CFG_RESET = '{
    setpoint:     '0,
    gain_p:       '0,
    gain_i:       '0,
    gain_d:       '0,
    out_max:      LIMITS_RESET[31:16],
    out_min:      LIMITS_RESET[15:0],
    int_max:      LIMITS_RESET[31:16],
    int_min:      LIMITS_RESET[15:0],
    int_clamp_en: 1'b0,
    drive_offset: OFFSET_RESET
  };

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_SETPOINT:     cfg_r.setpoint     <= cfg_wdata[15:0];
        REG_GAIN_P:       cfg_r.gain_p       <= cfg_wdata[15:0];
        REG_GAIN_I:       cfg_r.gain_i       <= cfg_wdata[15:0];
        REG_GAIN_D:       cfg_r.gain_d       <= cfg_wdata[15:0];
        REG_OUT_LIMITS: begin
          cfg_r.out_max <= cfg_wdata[31:16];
          cfg_r.out_min <= cfg_wdata[15:0];
        end
        REG_INT_LIMITS: begin
          cfg_r.int_max <= cfg_wdata[31:16];
          cfg_r.int_min <= cfg_wdata[15:0];
        end
        REG_INT_CLAMP_EN: cfg_r.int_clamp_en <= cfg_wdata[0];
        REG_DRIVE_OFFSET: cfg_r.drive_offset <= cfg_wdata[OffsetW-1:0];
        default:          cfg_r              <= cfg_r;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> hw/rtl/pidc_prod_stage.sv
// PID controller step: first stage, error and the three gain products.
// Holds the previous measurement. Depends on pidc_pkg.
`default_nettype none

module pidc_prod_stage (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              load,
  input  wire logic signed [pidc_pkg::MeasW-1:0] measurement,
  input  wire pidc_pkg::cfg_t                    cfg,
  output pidc_pkg::prod_t                        prod
);
  import pidc_pkg::*;

  logic signed [MeasW-1:0] prev_meas_r;
  logic signed [MeasW:0]   err;
  logic signed [MeasW:0]   diff;
  prod_t                   prod_r;
  prod_t                   prod_nxt;

  always_comb begin
    err        = (MeasW+1)'(cfg.setpoint) - (MeasW+1)'(measurement);
    diff       = (MeasW+1)'(prev_meas_r) - (MeasW+1)'(measurement);
    prod_nxt.p = ProdW'(cfg.gain_p) * ProdW'(err);
    prod_nxt.i = ProdW'(cfg.gain_i) * ProdW'(err);
    prod_nxt.d = ProdW'(cfg.gain_d) * ProdW'(diff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_meas_r <= '0;
    end else if (load) begin
      prev_meas_r <= measurement;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

>>> hw/rtl/pidc_sum_stage.sv
// PID controller step: second stage, integral update, sum, clamps and offset.
// Holds the integral accumulator and the result register. Depends on pidc_pkg.
`default_nettype none

module pidc_sum_stage #(
  parameter int unsigned GAIN_FRACTION_BITS = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               advance,
  input  wire pidc_pkg::prod_t                    prod,
  input  wire pidc_pkg::cfg_t                     cfg,
  output logic signed [pidc_pkg::DriveW-1:0]      drive,
  output logic                                    saturated
);
  import pidc_pkg::*;

  localparam int unsigned SumW = ProdW + 2;

  logic signed [AccW-1:0]   acc_r;
  logic signed [AccW-1:0]   acc_nxt;
  logic signed [33:0]       acc_raw;
  logic signed [33:0]       acc_c;
  logic signed [33:0]       int_hi;
  logic signed [33:0]       int_lo;
  logic signed [SumW-1:0]   total;
  logic signed [SumW-1:0]   sum;
  logic signed [SumW-1:0]   clamp_v;
  logic signed [15:0]       clamped;
  logic signed [DriveW-1:0] c_ext;
  logic signed [DriveW-1:0] off_ext;
  logic signed [DriveW-1:0] drive_r;
  logic signed [DriveW-1:0] drive_nxt;
  logic                     saturated_r;
  logic                     saturated_nxt;

  always_comb begin
    acc_raw = 34'(acc_r) + 34'(prod.i);
    acc_c   = acc_raw;
    if (acc_c > ACC_SAT_MAX) acc_c = ACC_SAT_MAX;
    if (acc_c < ACC_SAT_MIN) acc_c = ACC_SAT_MIN;

    int_hi = 34'(cfg.int_max) <<< GAIN_FRACTION_BITS;
    int_lo = 34'(cfg.int_min) <<< GAIN_FRACTION_BITS;
    if (cfg.int_clamp_en) begin
      if (acc_c > int_hi) acc_c = int_hi;
      if (acc_c < int_lo) acc_c = int_lo;
    end
    acc_nxt = acc_c[AccW-1:0];

    total   = SumW'(prod.p) + SumW'(acc_c) + SumW'(prod.d);
    sum     = total >>> GAIN_FRACTION_BITS;

    clamp_v = sum;
    if (clamp_v > SumW'(cfg.out_max)) clamp_v = SumW'(cfg.out_max);
    if (clamp_v < SumW'(cfg.out_min)) clamp_v = SumW'(cfg.out_min);
    saturated_nxt = (clamp_v != sum);
    clamped       = clamp_v[15:0];

    c_ext   = DriveW'(clamped);
    off_ext = signed'({{(DriveW-OffsetW){1'b0}}, cfg.drive_offset});
    if (clamped > 16'sd0) begin
      drive_nxt = c_ext + off_ext;
    end else if (clamped < 16'sd0) begin
      drive_nxt = c_ext - off_ext;
    end else begin
      drive_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (advance) begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      drive_r     <= drive_nxt;
      saturated_r <= saturated_nxt;
    end
  end

  assign drive     = drive_r;
  assign saturated = saturated_r;

endmodule

`default_nettype wire

>>> verif/tb.sv
// Self-checking bench for pid_controller_step: directed table, then random config phases.
// Depends on pidc_pkg and the pidc_in_if / pidc_out_if channel interfaces.
`timescale 1ns / 1ps

module tb;
  import pidc_pkg::*;

  localparam int FRAC        = 8;
  localparam int PHASES      = 14;
  localparam int PHASE_ITEMS = 125;
  localparam int N_ROWS      = 44;

  localparam longint ACC_TOP    = 64'sd2147483647;
  localparam longint ACC_BOTTOM = -64'sd2147483648;

  typedef struct packed {
    logic signed [DriveW-1:0] drive;
    logic                     saturated;
  } drive_beat_t;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_e;

  typedef struct packed {
    row_kind_e                kind;
    cfg_idx_t                 idx;
    logic [31:0]              data;
    logic signed [MeasW-1:0]  meas;
    logic                     typed;
    logic signed [DriveW-1:0] drive;
    logic                     sat;
  } step_row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;

  pidc_in_if  in_ch ();
  pidc_out_if out_ch ();

  pid_controller_step #(
    .GAIN_FRACTION_BITS(FRAC)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  cfg_t        cfg_shadow;
  longint      integral_acc;
  longint      prev_meas;
  int          walk_meas;
  drive_beat_t drive_expect_q [$];
  bit          send_idle;
  bit          recv_idle;
  int          mismatches;
  int          samples_sent;
  int          beats_checked;

  // typed rows: expected beat read straight off the control law
  step_row_t directed_rows [N_ROWS] = '{
    '{ROW_SAMPLE, REG_SETPOINT,     32'h0,         16'sd0,      1'b1, 17'sd0,      1'b0},
    '{ROW_SAMPLE, REG_SETPOINT,     32'h0,         16'sh7FFF,   1'b1, 17'sd0,      1'b0},
    '{ROW_SAMPLE, REG_SETPOINT,     32'h0,         16'sh8000,   1'b1, 17'sd0,      1'b0},
    '{ROW_WRITE,  REG_GAIN_P,       32'h0000_0100, 16'sd0,      1'b0, 17'sd0,      1'b0},
    '{ROW_SAMPLE, REG_SETPOINT,     32'h0,         -16'sd100,   1'b1, 17'sd250,    1'b0},
    '{ROW_SAMPLE, REG_SETPOINT,     32'h0,         16'sd100,    1'b1, -17'sd250,   1'b0},
    '{ROW_SAMPLE, REG_SETPOINT,     32'h0,         16'sh8000,   1'b1, 17'sd32917,  1'b1},
    '{ROW_SAMPLE, REG_SETPOINT,     32'h0,         16'sh7FFF,   1'b1, -17'sd32917, 1'b0},
    '{ROW_WRITE,  REG_DRIVE_OFFSET, 32'h0000_0FFF, 16'sd0,      1'b0, 17'sd0,      1'b0},
    '{ROW_SAMPLE, REG_SETPOINT,     32'h0,         16'sh8000,   1'b1, 17'sd36862,  1'b1},
    '{ROW_WRITE,  REG_GAIN_P,       32'h0000_FF00, 16'sd0,      1'b0, 17'sd0,      1'b0},
    '{ROW_SAMPLE, REG_SETPOINT,     32'h0,         16'sh8000,   1'b1, -17'sd36863, 1'b0},
    '{ROW_WRITE,  REG_DRIVE_OFFSET, 32'h0,         16'sd0,      1'b0, 17'sd0,      1'b0},
    '{ROW_SAMPLE, REG_SETPOINT,     32'h0,         -16'sd1,     1'b1, -17'sd1,     1'b0},
    '{ROW_WRITE,  REG_OUT_LIMITS,   32'hFFF6_000A, 16'sd0,      1'b0, 17'sd0,      1'b0},
    '{ROW_SAMPLE, REG_SETPOINT,     32'h0,         16'sd0,      1'b1, 17'sd10,     1'b1},
    '{ROW_WRITE,  REG_OUT_LIMITS,   32'h0000_0000, 16'sd0,      1'b0, 17'sd0,      1'b0},
    '{ROW_SAMPLE, REG_SETPOINT,     32'h0,         16'sd5,      1'b1, 17'sd0,      1'b1},
    '{ROW_WRITE,  REG_OUT_LIMITS,   32'h7FFF_8000, 16'sd0,      1'b0, 17'sd0,      1'b0},
    '{ROW_WRITE,  REG_GAIN_P,       32'h0,         16'sd0,      1'b0, 17'sd0,      1'b0},
    '{ROW_WRITE,  REG_DRIVE_OFFSET, 32'd150,       16'sd0,      1'b0, 17'sd0,      1'b0},
    '{ROW_WRITE,  REG_GAIN_I,       32'h0000_0100, 16'sd0,      1'b0, 17'sd0,      1'b0},
    '{ROW_WRITE,  REG_INT_LIMITS,   32'h0005_FFFB, 16'sd0,      1'b0, 17'sd0,      1'b0},
    '{ROW_WRITE,  REG_INT_CLAMP_EN, 32'h1,         16'sd0,      1'b0, 17'sd0,      1'b0},
    '{ROW_SAMPLE, REG_SETPOINT,     32'h0,         -16'sd100,   1'b1, 17'sd155,    1'b0},
    '{ROW_SAMPLE, REG_SETPOINT,     32'h0,         16'sd100,    1'b1, -17'sd155,   1'b0},
    '{ROW_WRITE,  REG_INT_CLAMP_EN, 32'h0,         16'sd0,      1'b0, 17'sd0,      1'b0},
    '{ROW_WRITE,  REG_GAIN_I,       32'h0000_7FFF, 16'sd0,      1'b0, 17'sd0,      1'b0},
    '{ROW_SAMPLE, REG_SETPOINT,     32'h0,         16'sh8000,   1'b0, 17'sd0,      1'b0},
    '{ROW_SAMPLE, REG_SETPOINT,     32'h0,         16'sh8000,   1'b0, 17'sd0,      1'b0},
    '{ROW_SAMPLE, REG_SETPOINT,     32'h0,         16'sh8000,   1'b0, 17'sd0,      1'b0},
    '{ROW_SAMPLE, REG_SETPOINT,     32'h0,         16'sh8000,   1'b0, 17'sd0,      1'b0},
    '{ROW_WRITE,  REG_GAIN_I,       32'h0000_8000, 16'sd0,      1'b0, 17'sd0,      1'b0},
    '{ROW_SAMPLE, REG_SETPOINT,     32'h0,         16'sh8000,   1'b0, 17'sd0,      1'b0},
    '{ROW_SAMPLE, REG_SETPOINT,     32'h0,         16'sh8000,   1'b0, 17'sd0,      1'b0},
    '{ROW_SAMPLE, REG_SETPOINT,     32'h0,         16'sh8000,   1'b0, 17'sd0,      1'b0},
    '{ROW_SAMPLE, REG_SETPOINT,     32'h0,         16'sh8000,   1'b0, 17'sd0,      1'b0},
    '{ROW_WRITE,  REG_GAIN_I,       32'h0,         16'sd0,      1'b0, 17'sd0,      1'b0},
    '{ROW_WRITE,  REG_GAIN_D,       32'h0000_7FFF, 16'sd0,      1'b0, 17'sd0,      1'b0},
    '{ROW_WRITE,  REG_SETPOINT,     32'h0000_7FFF, 16'sd0,      1'b0, 17'sd0,      1'b0},
    '{ROW_SAMPLE, REG_SETPOINT,     32'h0,         16'sh7FFF,   1'b0, 17'sd0,      1'b0},
    '{ROW_SAMPLE, REG_SETPOINT,     32'h0,         16'sh8000,   1'b0, 17'sd0,      1'b0},
    '{ROW_WRITE,  REG_SETPOINT,     32'h0000_8000, 16'sd0,      1'b0, 17'sd0,      1'b0},
    '{ROW_SAMPLE, REG_SETPOINT,     32'h0,         16'sh7FFF,   1'b0, 17'sd0,      1'b0}
  };

  function automatic drive_beat_t predict_drive(input logic signed [MeasW-1:0] meas);
    longint m, err, prop, acc, deriv, sum, clamped, drv, scale;
    longint omax, omin, imax, imin;
    drive_beat_t beat;
    scale = longint'(1) << FRAC;
    m     = meas;
    omax  = longint'($signed(cfg_shadow.out_max));
    omin  = longint'($signed(cfg_shadow.out_min));
    imax  = longint'($signed(cfg_shadow.int_max)) * scale;
    imin  = longint'($signed(cfg_shadow.int_min)) * scale;
    err   = longint'($signed(cfg_shadow.setpoint)) - m;
    prop  = longint'($signed(cfg_shadow.gain_p)) * err;
    acc   = integral_acc + longint'($signed(cfg_shadow.gain_i)) * err;
    deriv = -(longint'($signed(cfg_shadow.gain_d)) * (m - prev_meas));
    if (acc > ACC_TOP) acc = ACC_TOP;
    if (acc < ACC_BOTTOM) acc = ACC_BOTTOM;
    // max before min, so inverted limits settle on min
    if (cfg_shadow.int_clamp_en) begin
      if (acc > imax) acc = imax;
      if (acc < imin) acc = imin;
    end
    integral_acc = acc;
    prev_meas    = m;
    sum     = (prop + acc + deriv) >>> FRAC;
    clamped = sum;
    if (clamped > omax) clamped = omax;
    if (clamped < omin) clamped = omin;
    if (clamped > 0) begin
      drv = clamped + longint'(cfg_shadow.drive_offset);
    end else if (clamped < 0) begin
      drv = clamped - longint'(cfg_shadow.drive_offset);
    end else begin
      drv = 0;
    end
    beat.drive     = drv[DriveW-1:0];
    beat.saturated = (clamped != sum);
    return beat;
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'h0100;
      4: return 16'($urandom);
      default: return 16'(int'($urandom_range(0, 1024)) - 512);
    endcase
  endfunction

  function automatic logic [15:0] pick_setpoint();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom);
      default: return 16'(int'($urandom_range(0, 8000)) - 4000);
    endcase
  endfunction

  function automatic logic [31:0] pick_limits();
    int hi, lo;
    case ($urandom_range(0, 5))
      0: return LIMITS_RESET;
      1: begin
        lo = int'($urandom_range(0, 2000));
        hi = lo - int'($urandom_range(1, 2000));
      end
      2: return $urandom;
      default: begin
        lo = -int'($urandom_range(0, 3000));
        hi = int'($urandom_range(0, 3000));
      end
    endcase
    return {16'(hi), 16'(lo)};
  endfunction

  function automatic logic [OffsetW-1:0] pick_offset();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return OFFSET_RESET;
      default: return OffsetW'($urandom);
    endcase
  endfunction

  // mostly a settling trajectory towards the setpoint, with jumps and rail hits
  function automatic logic signed [MeasW-1:0] next_measurement();
    int sp, m;
    sp = $signed(cfg_shadow.setpoint);
    case ($urandom_range(0, 19))
      0: m = $signed(16'($urandom));
      1: m = 32767;
      2: m = -32768;
      default: m = walk_meas + (sp - walk_meas) / 8 + int'($urandom_range(0, 40)) - 20;
    endcase
    if (m > 32767) m = 32767;
    if (m < -32768) m = -32768;
    walk_meas = m;
    return 16'(m);
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_SETPOINT:     cfg_shadow.setpoint = data[15:0];
      REG_GAIN_P:       cfg_shadow.gain_p = data[15:0];
      REG_GAIN_I:       cfg_shadow.gain_i = data[15:0];
      REG_GAIN_D:       cfg_shadow.gain_d = data[15:0];
      REG_OUT_LIMITS:   {cfg_shadow.out_max, cfg_shadow.out_min} = data;
      REG_INT_LIMITS:   {cfg_shadow.int_max, cfg_shadow.int_min} = data;
      REG_INT_CLAMP_EN: cfg_shadow.int_clamp_en = data[0];
      REG_DRIVE_OFFSET: cfg_shadow.drive_offset = data[OffsetW-1:0];
    endcase
    @(posedge clk);
  endtask

  // sender holds off until every drive beat owed has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    cfg_we      <= 1'b0;
    while (drive_expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_sample(input logic signed [MeasW-1:0] m, input logic typed,
                             input logic signed [DriveW-1:0] typed_drive,
                             input logic typed_sat);
    int gap;
    drive_beat_t pred;
    gap = send_idle ? $urandom_range(0, 8) : 0;
    cfg_we <= 1'b0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.measurement <= m;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pred = predict_drive(m);
    if (typed) begin
      pred.drive     = typed_drive;
      pred.saturated = typed_sat;
    end
    drive_expect_q.push_back(pred);
    samples_sent++;
  endtask

  task automatic randomise_config();
    write_reg(REG_SETPOINT,     {16'($urandom), pick_setpoint()});
    write_reg(REG_GAIN_P,       {16'($urandom), pick_gain()});
    write_reg(REG_GAIN_I,       {16'($urandom), pick_gain()});
    write_reg(REG_GAIN_D,       {16'($urandom), pick_gain()});
    write_reg(REG_OUT_LIMITS,   pick_limits());
    write_reg(REG_INT_LIMITS,   pick_limits());
    write_reg(REG_INT_CLAMP_EN, {31'($urandom), 1'($urandom)});
    write_reg(REG_DRIVE_OFFSET, {20'($urandom), pick_offset()});
  endtask

  initial begin : drive_checker
    drive_beat_t want;
    int stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      stall = recv_idle ? $urandom_range(0, 8) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      beats_checked++;
      if (drive_expect_q.size() == 0) begin
        $error("drive beat with nothing expected: drive=%0d saturated=%0b",
               $signed(out_ch.drive), out_ch.saturated);
        mismatches++;
      end else begin
        want = drive_expect_q.pop_front();
        if (out_ch.drive !== want.drive) begin
          $error("drive: expected %0d, got %0d", $signed(want.drive), $signed(out_ch.drive));
          mismatches++;
        end
        if (out_ch.saturated !== want.saturated) begin
          $error("saturated: expected %0b, got %0b", want.saturated, out_ch.saturated);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= '0;
    cfg_wdata         <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.measurement <= '0;
    cfg_shadow    = '0;
    {cfg_shadow.out_max, cfg_shadow.out_min} = LIMITS_RESET;
    {cfg_shadow.int_max, cfg_shadow.int_min} = LIMITS_RESET;
    cfg_shadow.drive_offset = OFFSET_RESET;
    integral_acc  = 0;
    prev_meas     = 0;
    walk_meas     = 0;
    mismatches    = 0;
    samples_sent  = 0;
    beats_checked = 0;
    send_idle     = 1'b1;
    recv_idle     = 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_WRITE) begin
        drain();
        write_reg(directed_rows[r].idx, directed_rows[r].data);
      end else begin
        send_sample(directed_rows[r].meas, directed_rows[r].typed,
                    directed_rows[r].drive, directed_rows[r].sat);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      randomise_config();
      send_idle = (ph == 0) ? 1'b0 : (ph == 1) ? 1'b1 : 1'($urandom);
      recv_idle = (ph == 0) ? 1'b0 : (ph == 1) ? 1'b1 : 1'($urandom);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 6 && k == PHASE_ITEMS / 2) drain();
        send_sample(next_measurement(), 1'b0, '0, 1'b0);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Covered %0d samples: directed extremes, then %0d random gain/limit settings.",
             samples_sent, PHASES);
    $display("%0d drive beats checked against the predicted control law.", beats_checked);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
